[sv/smdg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smdg_pkg
// shared types and constants for the stereo modulated delay/gain core
// ----------------------------------------------------------------------------
package smdg_pkg;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 17;
    localparam logic [COEF_W-1:0] UNITY = 17'd65536;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -24'sh800000;

    typedef enum logic [2:0] {
        CFG_DELAY_SPAN     = 3'd0,
        CFG_SMOOTH_COEF    = 3'd1,
        CFG_ATTACK_COEF    = 3'd2,
        CFG_RELEASE_COEF   = 3'd3,
        CFG_MIX_AMOUNT     = 3'd4,
        CFG_JUMP_THRESHOLD = 3'd5,
        CFG_XFADE_STEP     = 3'd6,
        CFG_EFFECT_ON      = 3'd7
    } smdg_cfg_idx_t;

    typedef struct packed {
        logic [15:0]       delay_span;
        logic [COEF_W-1:0] smooth_coef;
        logic [COEF_W-1:0] attack_coef;
        logic [COEF_W-1:0] release_coef;
        logic [COEF_W-1:0] mix_amount;
        logic [15:0]       jump_threshold;
        logic [13:0]       crossfade_step;
        logic              effect_on;
    } smdg_cfg_t;

    // per-sample levels handed from control to the lanes
    typedef struct packed {
        logic [COEF_W-1:0] fade_level;
        logic [COEF_W-1:0] gain_level;
        logic [COEF_W-1:0] amt;
    } smdg_mix_t;

    function automatic logic [COEF_W-1:0] sat_unity(input logic [COEF_W-1:0] c);
        sat_unity = c[COEF_W-1] ? UNITY : c;
    endfunction

endpackage : smdg_pkg
`default_nettype wire

[sv/smdg_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smdg_ctrl
// delay target, glide/jump, crossfade, gain envelope and bypass ramp state
// ----------------------------------------------------------------------------
module smdg_ctrl
    import smdg_pkg::*;
#(
    parameter int RING_DEPTH          = 65536,
    parameter int BYPASS_RAMP_SAMPLES = 256,
    localparam int AW = $clog2(RING_DEPTH),
    localparam int DW = AW + 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire smdg_cfg_t           cfg,
    input  wire logic                start,
    input  wire logic [COEF_W-1:0]   delay_env,
    input  wire logic [COEF_W-1:0]   gain_env,
    input  wire logic                commit,
    output logic                     done,
    output logic [AW-1:0]            wr_index,
    output logic                     wrapped,
    output logic [DW-1:0]            delay_cur,
    output logic [DW-1:0]            delay_fade,
    output smdg_mix_t                mix
);

    localparam int XW = (DW > 33) ? DW : 33;
    localparam int YW = (DW + 1 > 32) ? DW + 1 : 32;
    localparam int GW = DW + 18;
    localparam logic [DW-1:0] MAX_DELAY = DW'(64'(RING_DEPTH - 8) << 16);
    localparam logic [DW-1:0] MIN_DELAY = DW'(64'(2) << 16);
    localparam int STEP_RAW = 65536 / BYPASS_RAMP_SAMPLES;
    localparam logic [COEF_W-1:0] BYP_STEP = COEF_W'((STEP_RAW < 1) ? 1 : STEP_RAW);

    typedef enum logic [2:0] {C_IDLE, C_TGT, C_GLIDE, C_UPD, C_AMT} state_t;

    state_t                  state_reg;
    logic                    done_reg;
    logic [COEF_W-1:0]       denv_reg;
    logic [COEF_W-1:0]       genv_reg;
    logic [32:0]             tprod_reg;
    logic signed [35:0]      gprod_reg;
    logic signed [GW-1:0]    glprod_reg;
    logic [33:0]             aprod_reg;
    logic [AW-1:0]           wi_reg;
    logic                    wrapped_reg;
    logic                    primed_reg;
    logic [DW-1:0]           cur_reg;
    logic [DW-1:0]           prev_reg;
    logic [DW-1:0]           fade_delay_reg;
    logic [COEF_W-1:0]       fade_level_reg;
    logic [COEF_W-1:0]       fade_use_reg;
    logic [COEF_W-1:0]       gain_reg;
    logic [COEF_W-1:0]       bypass_reg;
    logic [COEF_W-1:0]       amt_reg;

    logic [XW-1:0]           tx;
    logic [DW-1:0]           target;
    logic signed [DW:0]      tdiff;
    logic [DW:0]             tabs;
    logic                    is_jump;
    logic signed [DW:0]      gldiff;
    logic signed [DW+1:0]    cur_sum;
    logic signed [17:0]      gdiff;
    logic [COEF_W-1:0]       gcoef;
    logic signed [18:0]      gain_sum;
    logic [COEF_W:0]         byp_up;
    logic [COEF_W-1:0]       byp_next;
    logic [COEF_W:0]         fade_sub;

    always_comb
    begin
        tx = XW'(tprod_reg);
        if (tx > XW'(MAX_DELAY))
            target = MAX_DELAY;
        else
            target = DW'(tx);
        if (target != '0 && target < MIN_DELAY)
            target = MIN_DELAY;

        tdiff   = $signed({1'b0, target}) - $signed({1'b0, prev_reg});
        tabs    = tdiff[DW] ? (DW+1)'(-tdiff) : (DW+1)'(tdiff);
        is_jump = (YW'(tabs) > YW'({cfg.jump_threshold, 16'h0000})) && primed_reg;

        gldiff  = $signed({1'b0, target}) - $signed({1'b0, cur_reg});
        cur_sum = $signed({2'b00, cur_reg})
                + (DW+2)'((glprod_reg + GW'(32768)) >>> 16);

        gdiff    = $signed({1'b0, genv_reg}) - $signed({1'b0, gain_reg});
        gcoef    = (genv_reg > gain_reg) ? sat_unity(cfg.attack_coef)
                                         : sat_unity(cfg.release_coef);
        gain_sum = $signed({2'b00, gain_reg}) + 19'((gprod_reg + 36'sd32768) >>> 16);

        byp_up = {1'b0, bypass_reg} + {1'b0, BYP_STEP};
        if (cfg.effect_on)
            byp_next = (byp_up > {1'b0, UNITY}) ? UNITY : COEF_W'(byp_up);
        else
            byp_next = (bypass_reg < BYP_STEP) ? '0 : bypass_reg - BYP_STEP;

        fade_sub = {1'b0, fade_level_reg} - {4'b0000, cfg.crossfade_step};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= C_IDLE;
            done_reg       <= 1'b0;
            wi_reg         <= '0;
            wrapped_reg    <= 1'b0;
            primed_reg     <= 1'b0;
            cur_reg        <= '0;
            prev_reg       <= '0;
            fade_delay_reg <= '0;
            fade_level_reg <= '0;
            fade_use_reg   <= '0;
            gain_reg       <= UNITY;
            bypass_reg     <= UNITY;
            amt_reg        <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (commit)
            begin
                wi_reg     <= wi_reg + 1'b1;
                primed_reg <= 1'b1;
                if (wi_reg == '1)
                    wrapped_reg <= 1'b1;
            end
            unique case (state_reg)
                C_IDLE:
                begin
                    if (start)
                        state_reg <= C_TGT;
                end
                C_TGT:
                begin
                    state_reg <= C_GLIDE;
                end
                C_GLIDE:
                begin
                    prev_reg   <= target;
                    gain_reg   <= COEF_W'(gain_sum);
                    bypass_reg <= byp_next;
                    if (cfg.smooth_coef[COEF_W-1])
                    begin
                        cur_reg <= target;
                        if (is_jump)
                        begin
                            fade_delay_reg <= cur_reg;
                            fade_level_reg <= UNITY;
                        end
                    end
                    state_reg <= C_UPD;
                end
                C_UPD:
                begin
                    if (!cfg.smooth_coef[COEF_W-1])
                        cur_reg <= DW'(cur_sum);
                    fade_use_reg <= fade_level_reg;
                    if (fade_level_reg != '0)
                        fade_level_reg <= fade_sub[COEF_W] ? '0 : COEF_W'(fade_sub);
                    state_reg <= C_AMT;
                end
                C_AMT:
                begin
                    amt_reg   <= COEF_W'((aprod_reg + 34'd32768) >> 16);
                    done_reg  <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    // arithmetic datapath registers
    always_ff @(posedge clk)
    begin
        if (start && state_reg == C_IDLE)
        begin
            denv_reg <= delay_env;
            genv_reg <= gain_env;
        end
        tprod_reg  <= 33'(denv_reg) * 33'(cfg.delay_span);
        gprod_reg  <= 36'(gdiff) * $signed({19'b0, gcoef});
        glprod_reg <= GW'(gldiff) * $signed({{(GW-16){1'b0}}, cfg.smooth_coef[15:0]});
        aprod_reg  <= 34'(sat_unity(cfg.mix_amount)) * 34'(bypass_reg);
    end

    assign done           = done_reg;
    assign wr_index       = wi_reg;
    assign wrapped        = wrapped_reg;
    assign delay_cur      = cur_reg;
    assign delay_fade     = fade_delay_reg;
    assign mix.fade_level = fade_use_reg;
    assign mix.gain_level = gain_reg;
    assign mix.amt        = amt_reg;

endmodule : smdg_ctrl
`default_nettype wire

[sv/smdg_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smdg_lane
// one channel: ring buffer, hermite read of one or two heads, fade, gain, mix
// ----------------------------------------------------------------------------
module smdg_lane
    import smdg_pkg::*;
#(
    parameter int RING_DEPTH = 65536,
    localparam int AW = $clog2(RING_DEPTH),
    localparam int DW = AW + 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       ack,
    input  wire logic signed [SAMPLE_W-1:0] dry,
    input  wire logic [AW-1:0]              wr_index,
    input  wire logic                       wrapped,
    input  wire logic [DW-1:0]              delay_cur,
    input  wire logic [DW-1:0]              delay_fade,
    input  wire smdg_mix_t                  mix,
    output logic                            done,
    output logic signed [SAMPLE_W-1:0]      wet
);

    localparam int PW = 51;

    typedef enum logic [3:0] {
        L_IDLE, L_WRITE, L_READ, L_H1, L_H2, L_H3, L_H4, L_PICK,
        L_F1, L_F2, L_F3, L_G1, L_G2, L_M1, L_M2, L_DONE
    } state_t;

    logic signed [SAMPLE_W-1:0] mem [RING_DEPTH];

    state_t                     state_reg;
    logic [2:0]                 tap_reg;
    logic                       head_b_reg;
    logic                       rd_live_reg;
    logic                       rd_ok_reg;
    logic [1:0]                 rd_slot_reg;
    logic signed [SAMPLE_W-1:0] rd_q;
    logic [AW-1:0]              base_reg;
    logic [15:0]                t_reg;
    logic signed [SAMPLE_W-1:0] x_reg [4];
    logic signed [SAMPLE_W-1:0] dry_reg;
    logic signed [PW-1:0]       prod_reg;
    logic signed [PW-1:0]       pa_reg;
    logic signed [31:0]         y_reg;
    logic signed [31:0]         wa_reg;
    logic signed [31:0]         w_reg;
    logic signed [SAMPLE_W-1:0] wet_reg;

    logic [DW-1:0]              pos;
    logic [AW-1:0]              rd_addr;
    logic                       rd_ok;
    logic signed [32:0]         c2;
    logic signed [32:0]         vv;
    logic signed [32:0]         w2;
    logic signed [32:0]         a2;
    logic signed [32:0]         b2;
    logic signed [32:0]         rs16;
    logic signed [32:0]         rs17;
    logic signed [PW:0]         fsum;
    logic signed [33:0]         mix_sum;
    logic signed [32:0]         mul_a;
    logic signed [17:0]         mul_b;
    logic signed [PW-1:0]       mul_p;
    logic signed [17:0]         t_s;

    always_comb
    begin
        pos     = {wr_index, 16'h0000} - ((state_reg == L_PICK) ? delay_fade : delay_cur);
        rd_addr = base_reg + AW'(tap_reg) - AW'(1);
        rd_ok   = wrapped || (rd_addr <= wr_index);

        c2 = 33'(x_reg[2]) - 33'(x_reg[0]);
        vv = 33'(x_reg[1]) - 33'(x_reg[2]);
        w2 = c2 + (vv <<< 1);
        a2 = w2 + (vv <<< 1) + (33'(x_reg[3]) - 33'(x_reg[1]));
        b2 = w2 + a2;

        rs16    = 33'((prod_reg + PW'(32768)) >>> 16);
        rs17    = 33'((prod_reg + PW'(65536)) >>> 17);
        fsum    = (PW+1)'(pa_reg) + (PW+1)'(prod_reg) + (PW+1)'(32768);
        mix_sum = 34'(dry_reg) + 34'((prod_reg + PW'(32768)) >>> 16);

        t_s = $signed({2'b00, t_reg});
        unique case (state_reg)
            L_H1:
            begin
                mul_a = a2;
                mul_b = t_s;
            end
            L_H2:
            begin
                mul_a = rs16 - b2;
                mul_b = t_s;
            end
            L_H3:
            begin
                mul_a = rs16 + c2;
                mul_b = t_s;
            end
            L_F1:
            begin
                mul_a = 33'(wa_reg);
                mul_b = $signed({1'b0, UNITY - mix.fade_level});
            end
            L_F2:
            begin
                mul_a = 33'(y_reg);
                mul_b = $signed({1'b0, mix.fade_level});
            end
            L_G1:
            begin
                mul_a = 33'(w_reg);
                mul_b = $signed({1'b0, mix.gain_level});
            end
            L_M1:
            begin
                mul_a = 33'(w_reg) - 33'(dry_reg);
                mul_b = $signed({1'b0, mix.amt});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PW'(mul_a) * PW'(mul_b);
    end

    // ring buffer, one port: sample write then tap reads
    always_ff @(posedge clk)
    begin
        if (state_reg == L_WRITE)
            mem[wr_index] <= dry_reg;
        rd_q <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= L_IDLE;
            rd_live_reg <= 1'b0;
            head_b_reg  <= 1'b0;
            tap_reg     <= '0;
        end
        else
        begin
            rd_live_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE:
                begin
                    if (start)
                        state_reg <= L_WRITE;
                end
                L_WRITE:
                begin
                    head_b_reg <= 1'b0;
                    tap_reg    <= '0;
                    state_reg  <= L_READ;
                end
                L_READ:
                begin
                    if (tap_reg != 3'd4)
                    begin
                        rd_live_reg <= 1'b1;
                        tap_reg     <= tap_reg + 3'd1;
                    end
                    else
                        state_reg <= L_H1;
                end
                L_H1: state_reg <= L_H2;
                L_H2: state_reg <= L_H3;
                L_H3: state_reg <= L_H4;
                L_H4: state_reg <= L_PICK;
                L_PICK:
                begin
                    if (head_b_reg)
                        state_reg <= L_F1;
                    else if (mix.fade_level != '0)
                    begin
                        head_b_reg <= 1'b1;
                        tap_reg    <= '0;
                        state_reg  <= L_READ;
                    end
                    else
                        state_reg <= L_G1;
                end
                L_F1: state_reg <= L_F2;
                L_F2: state_reg <= L_F3;
                L_F3: state_reg <= L_G1;
                L_G1: state_reg <= L_G2;
                L_G2: state_reg <= L_M1;
                L_M1: state_reg <= L_M2;
                L_M2: state_reg <= L_DONE;
                L_DONE:
                begin
                    if (ack)
                        state_reg <= L_IDLE;
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (state_reg == L_IDLE && start)
            dry_reg <= dry;
        if (state_reg == L_WRITE || (state_reg == L_PICK && !head_b_reg))
        begin
            base_reg <= pos[DW-1:16];
            t_reg    <= pos[15:0];
        end
        if (state_reg == L_READ)
        begin
            rd_slot_reg <= tap_reg[1:0];
            rd_ok_reg   <= rd_ok;
        end
        if (rd_live_reg)
            x_reg[rd_slot_reg] <= rd_ok_reg ? rd_q : '0;
        if (state_reg == L_H4)
            y_reg <= 32'(33'(x_reg[1]) + rs17);
        // main head value kept aside while the fade head is read
        if (state_reg == L_PICK && !head_b_reg)
        begin
            wa_reg <= y_reg;
            w_reg  <= y_reg;
        end
        if (state_reg == L_F2)
            pa_reg <= prod_reg;
        if (state_reg == L_F3)
            w_reg <= 32'(fsum >>> 16);
        if (state_reg == L_G2)
            w_reg <= 32'(rs16);
        if (state_reg == L_M2)
        begin
            if (mix_sum > 34'(SAMPLE_MAX))
                wet_reg <= SAMPLE_MAX;
            else if (mix_sum < 34'(SAMPLE_MIN))
                wet_reg <= SAMPLE_MIN;
            else
                wet_reg <= SAMPLE_W'(mix_sum);
        end
    end

    assign done = (state_reg == L_DONE);
    assign wet  = wet_reg;

endmodule : smdg_lane
`default_nettype wire

[sv/stereo_modulated_delay_gain_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_modulated_delay_gain_core
// stereo hermite-interpolated variable delay with crossfade, gain and mix
// ----------------------------------------------------------------------------
// one sample in flight at a time: a new input is taken only after the previous
//   result has been loaded into the output register, which waits while it is
//   full; the pace is set by the four single-port ring reads per head and the
//   shared multiplier in each lane, and a crossfade adds the read of a second head
// reset: all control state cleared, gain and bypass at unity; ring entries not
//   yet written read as zero via write index and wrap flag, no clearing pass
module stereo_modulated_delay_gain_core
    import smdg_pkg::*;
#(
    parameter int RING_DEPTH          = 65536,
    parameter int BYPASS_RAMP_SAMPLES = 256
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [SAMPLE_W-1:0] dry_left,
    input  wire logic signed [SAMPLE_W-1:0] dry_right,
    input  wire logic [COEF_W-1:0]          delay_env,
    input  wire logic [COEF_W-1:0]          gain_env,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [SAMPLE_W-1:0]      out_left,
    output logic signed [SAMPLE_W-1:0]      out_right,
    input  wire logic                       cfg_write,
    input  wire logic [2:0]                 cfg_index,
    input  wire logic [COEF_W-1:0]          cfg_data
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int DW = AW + 16;

    typedef enum logic [1:0] {T_IDLE, T_CTRL, T_LANES} state_t;

    state_t                     state_reg;
    smdg_cfg_t                  cfg_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_left_reg;
    logic signed [SAMPLE_W-1:0] out_right_reg;
    logic signed [SAMPLE_W-1:0] dry_l_reg;
    logic signed [SAMPLE_W-1:0] dry_r_reg;

    logic                       in_fire;
    logic                       ctrl_done;
    logic                       lane_start;
    logic                       done_l;
    logic                       done_r;
    logic                       load;
    logic [AW-1:0]              wr_index;
    logic                       wrapped;
    logic [DW-1:0]              delay_cur;
    logic [DW-1:0]              delay_fade;
    smdg_mix_t                  mix;
    logic signed [SAMPLE_W-1:0] wet_l;
    logic signed [SAMPLE_W-1:0] wet_r;

    assign in_ready   = (state_reg == T_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign lane_start = (state_reg == T_CTRL) && ctrl_done;
    assign load       = (state_reg == T_LANES) && done_l && done_r
                        && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delay_span     <= '0;
            cfg_reg.smooth_coef    <= UNITY;
            cfg_reg.attack_coef    <= UNITY;
            cfg_reg.release_coef   <= UNITY;
            cfg_reg.mix_amount     <= UNITY;
            cfg_reg.jump_threshold <= 16'd44;
            cfg_reg.crossfade_step <= 14'd1489;
            cfg_reg.effect_on      <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (smdg_cfg_idx_t'(cfg_index))
                CFG_DELAY_SPAN:     cfg_reg.delay_span     <= cfg_data[15:0];
                CFG_SMOOTH_COEF:    cfg_reg.smooth_coef    <= cfg_data;
                CFG_ATTACK_COEF:    cfg_reg.attack_coef    <= cfg_data;
                CFG_RELEASE_COEF:   cfg_reg.release_coef   <= cfg_data;
                CFG_MIX_AMOUNT:     cfg_reg.mix_amount     <= cfg_data;
                CFG_JUMP_THRESHOLD: cfg_reg.jump_threshold <= cfg_data[15:0];
                CFG_XFADE_STEP:     cfg_reg.crossfade_step <= cfg_data[13:0];
                CFG_EFFECT_ON:      cfg_reg.effect_on      <= cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                T_IDLE:
                begin
                    if (in_fire)
                        state_reg <= T_CTRL;
                end
                T_CTRL:
                begin
                    if (ctrl_done)
                        state_reg <= T_LANES;
                end
                T_LANES:
                begin
                    if (load)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    // dry samples held for the lanes once the input transaction is taken
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            dry_l_reg <= dry_left;
            dry_r_reg <= dry_right;
        end
    end

    // merge both lanes into the output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_left_reg  <= wet_l;
            out_right_reg <= wet_r;
        end
    end

    smdg_ctrl #(
        .RING_DEPTH          (RING_DEPTH),
        .BYPASS_RAMP_SAMPLES (BYPASS_RAMP_SAMPLES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .start      (in_fire),
        .delay_env  (delay_env),
        .gain_env   (gain_env),
        .commit     (load),
        .done       (ctrl_done),
        .wr_index   (wr_index),
        .wrapped    (wrapped),
        .delay_cur  (delay_cur),
        .delay_fade (delay_fade),
        .mix        (mix)
    );

    smdg_lane #(
        .RING_DEPTH (RING_DEPTH)
    ) u_lane_l (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (lane_start),
        .ack        (load),
        .dry        (dry_l_reg),
        .wr_index   (wr_index),
        .wrapped    (wrapped),
        .delay_cur  (delay_cur),
        .delay_fade (delay_fade),
        .mix        (mix),
        .done       (done_l),
        .wet        (wet_l)
    );

    smdg_lane #(
        .RING_DEPTH (RING_DEPTH)
    ) u_lane_r (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (lane_start),
        .ack        (load),
        .dry        (dry_r_reg),
        .wr_index   (wr_index),
        .wrapped    (wrapped),
        .delay_cur  (delay_cur),
        .delay_fade (delay_fade),
        .mix        (mix),
        .done       (done_r),
        .wet        (wet_r)
    );

    assign out_valid = out_valid_reg;
    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("input taken while a transaction is in flight");

    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        done_l == done_r)
        else $error("lanes out of step");

    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    a_levels_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_LANES) |-> (mix.fade_level <= UNITY && mix.amt <= UNITY
                                    && mix.gain_level <= UNITY))
        else $error("level above unity");

endmodule : stereo_modulated_delay_gain_core
`default_nettype wire
